// ===== design/lras_pkg.sv =====
package lras_pkg;

  localparam int unsigned CoordBitsDef = 6;
  localparam int unsigned ColorBits    = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic span;
    logic orient;
    logic step;
  } lras_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic at_end;
  } lras_stat_t;

endpackage

// ===== design/line_rasterizer.sv =====
// The first pixel is presented after the span and orient states and the first step.
// A line of N pixels (major span plus one, at most 2^COORD_BITS) is emitted by the
// stepping loop, one pixel per cycle while the output register is free.
// The next line is taken once the final pixel has entered the output register.
// Reset (rst_ni, asynchronous, active low) clears the controller and the output valid.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = lras_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COORD_BITS-1:0]          start_x_i,
  input  logic [COORD_BITS-1:0]          start_y_i,
  input  logic [COORD_BITS-1:0]          end_x_i,
  input  logic [COORD_BITS-1:0]          end_y_i,
  input  logic [lras_pkg::ColorBits-1:0] pen_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [COORD_BITS-1:0]          pixel_x_o,
  output logic [COORD_BITS-1:0]          pixel_y_o,
  output logic [lras_pkg::ColorBits-1:0] pixel_color_o,
  output logic                           last_pixel_o
);
  import lras_pkg::*;

  lras_cmd_t  cmd;
  lras_stat_t stat;

  lras_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lras_dp #(
    .CoordBits (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pen_color_i   (pen_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ===== design/lras_ctrl.sv =====
module lras_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lras_pkg::lras_stat_t stat_i,
  output lras_pkg::lras_cmd_t  cmd_o
);
  import lras_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSpan,
    StOrient,
    StRun
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    cmd_o.load   = (state_q == StIdle) && in_valid_i;
    cmd_o.span   = (state_q == StSpan);
    cmd_o.orient = (state_q == StOrient);
    cmd_o.step   = (state_q == StRun) && stat_i.out_free;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSpan;
        end
      end
      StSpan:   state_d = StOrient;
      StOrient: state_d = StRun;
      StRun: begin
        // The final pixel has moved into the output register.
        if (stat_i.out_free && stat_i.at_end) begin
          state_d = StIdle;
        end
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== design/lras_dp.sv =====
module lras_dp #(
  parameter int unsigned CoordBits = lras_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lras_pkg::lras_cmd_t           cmd_i,
  output lras_pkg::lras_stat_t          stat_o,
  input  logic [CoordBits-1:0]          start_x_i,
  input  logic [CoordBits-1:0]          start_y_i,
  input  logic [CoordBits-1:0]          end_x_i,
  input  logic [CoordBits-1:0]          end_y_i,
  input  logic [lras_pkg::ColorBits-1:0] pen_color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CoordBits-1:0]          pixel_x_o,
  output logic [CoordBits-1:0]          pixel_y_o,
  output logic [lras_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          last_pixel_o
);
  import lras_pkg::*;

  localparam int unsigned W  = CoordBits;
  localparam int unsigned EW = CoordBits + 2;
  localparam logic [W-1:0] One = {{(W-1){1'b0}}, 1'b1};

  // Latched endpoints and colour.
  logic [W-1:0]         ax_q, ay_q, bx_q, by_q;
  logic [ColorBits-1:0] color_q;
  // Endpoints sorted into major and minor axis.
  logic [W-1:0]         a0_q, a1_q, b0_q, b1_q, a0_d, a1_d, b0_d, b1_d;
  logic                 steep_q, steep_d;
  // Stepping state.
  logic [W-1:0]         cur_maj_q, cur_maj_d, end_maj_q, end_maj_d;
  logic [W-1:0]         cur_min_q, cur_min_d, dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic                 up_q, up_d;
  logic signed [EW-1:0] err_q, err_d;
  // Output register.
  logic                 out_valid_q;
  logic [W-1:0]         pix_x_q, pix_y_q;
  logic [ColorBits-1:0] pix_color_q;
  logic                 pix_last_q;

  logic [W-1:0]         dx, dy, lo, hi, bs, be;
  logic                 swap;
  logic signed [EW-1:0] e1, err_step;
  logic [W-1:0]         min_step;

  // Span cycle: choose the major axis.
  always_comb begin
    dx      = (bx_q >= ax_q) ? (bx_q - ax_q) : (ax_q - bx_q);
    dy      = (by_q >= ay_q) ? (by_q - ay_q) : (ay_q - by_q);
    steep_d = (dy > dx);
    a0_d    = steep_d ? ay_q : ax_q;
    a1_d    = steep_d ? by_q : bx_q;
    b0_d    = steep_d ? ax_q : ay_q;
    b1_d    = steep_d ? bx_q : by_q;
  end

  // Orient cycle: run in increasing major coordinate.
  always_comb begin
    swap      = (a0_q > a1_q);
    lo        = swap ? a1_q : a0_q;
    hi        = swap ? a0_q : a1_q;
    bs        = swap ? b1_q : b0_q;
    be        = swap ? b0_q : b1_q;
    dmaj_d    = hi - lo;
    up_d      = (bs < be);
    dmin_d    = up_d ? (be - bs) : (bs - be);
    end_maj_d = hi;
  end

  // Step: error update and minor axis advance.
  always_comb begin
    e1       = err_q - $signed({2'b00, dmin_q});
    min_step = up_q ? (cur_min_q + One) : (cur_min_q - One);
    if (e1[EW-1]) begin
      err_step  = e1 + $signed({2'b00, dmaj_q});
      cur_min_d = min_step;
    end else begin
      err_step  = e1;
      cur_min_d = cur_min_q;
    end
    cur_maj_d = cur_maj_q + One;
    err_d     = err_step;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= pen_color_i;
    end
    if (cmd_i.span) begin
      steep_q <= steep_d;
      a0_q    <= a0_d;
      a1_q    <= a1_d;
      b0_q    <= b0_d;
      b1_q    <= b1_d;
    end
    if (cmd_i.orient) begin
      cur_maj_q <= lo;
      end_maj_q <= end_maj_d;
      cur_min_q <= bs;
      dmaj_q    <= dmaj_d;
      dmin_q    <= dmin_d;
      up_q      <= up_d;
      err_q     <= $signed({2'b00, dmaj_d >> 1});
    end
    if (cmd_i.step) begin
      cur_maj_q   <= cur_maj_d;
      cur_min_q   <= cur_min_d;
      err_q       <= err_d;
      pix_x_q     <= steep_q ? cur_min_q : cur_maj_q;
      pix_y_q     <= steep_q ? cur_maj_q : cur_min_q;
      pix_color_q <= color_q;
      pix_last_q  <= (cur_maj_q == end_maj_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.at_end   = (cur_maj_q == end_maj_q);

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_pixel_o  = pix_last_q;

`ifndef NO_ASSERTIONS
  // A pixel must never overwrite one that is still waiting for its transfer.
  a_step_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (!out_valid_q || !out_stall_i))
    else $error("step while output register is occupied");

  // The error term is never left negative after an update.
  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.orient) |=> !err_q[EW-1])
    else $error("error term negative after update");

  // Stepping never runs past the far endpoint.
  a_maj_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (cur_maj_q <= end_maj_q))
    else $error("major coordinate beyond far endpoint");
`endif

endmodule

// ===== test/tb_line_rasterizer.sv =====
module tb_line_rasterizer;

  localparam int unsigned CW = lras_pkg::CoordBitsDef;
  localparam int unsigned PW = lras_pkg::ColorBits;
  localparam int unsigned CMAX = (1 << CW) - 1;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [PW-1:0] color;
  } line_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [PW-1:0] color;
    logic          last;
  } pixel_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [CW-1:0] start_x_i = '0;
  logic [CW-1:0] start_y_i = '0;
  logic [CW-1:0] end_x_i = '0;
  logic [CW-1:0] end_y_i = '0;
  logic [PW-1:0] pen_color_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CW-1:0] pixel_x_o;
  logic [CW-1:0] pixel_y_o;
  logic [PW-1:0] pixel_color_o;
  logic          last_pixel_o;

  line_t       lines_to_send[$];
  pixel_t      pixels_due[$];
  line_t       on_offer;
  pixel_t      want;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic        draining = 1'b0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  int          lines_drawn = 0;
  int          pixels_seen = 0;

  line_rasterizer #(.COORD_BITS(CW)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pen_color_i  (pen_color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int coord_dist(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int nudge(int c);
    int v;
    v = c + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > int'(CMAX)) v = CMAX;
    return v;
  endfunction

  // Walks the line along its major axis and queues every pixel it covers.
  function automatic void trace_line(line_t ln);
    int lead0, lead1, side0, side1, tmp;
    int lead_span, side_span, err, side_dir;
    bit steep;
    pixel_t px;
    steep = coord_dist(ln.ey, ln.sy) > coord_dist(ln.ex, ln.sx);
    if (steep) begin
      lead0 = ln.sy; side0 = ln.sx; lead1 = ln.ey; side1 = ln.ex;
    end else begin
      lead0 = ln.sx; side0 = ln.sy; lead1 = ln.ex; side1 = ln.ey;
    end
    if (lead0 > lead1) begin
      tmp = lead0; lead0 = lead1; lead1 = tmp;
      tmp = side0; side0 = side1; side1 = tmp;
    end
    lead_span = lead1 - lead0;
    side_span = coord_dist(side1, side0);
    err = lead_span / 2;
    side_dir = (side0 < side1) ? 1 : -1;
    for (int lead = lead0; lead <= lead1; lead++) begin
      px.x = steep ? CW'(side0) : CW'(lead);
      px.y = steep ? CW'(lead) : CW'(side0);
      px.color = ln.color;
      px.last = (lead == lead1);
      pixels_due.push_back(px);
      err -= side_span;
      if (err < 0) begin
        side0 += side_dir;
        err += lead_span;
      end
    end
  endfunction

  function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic queue_line(int sx, int sy, int ex, int ey, int color);
    line_t ln;
    ln.sx = CW'(sx);
    ln.sy = CW'(sy);
    ln.ex = CW'(ex);
    ln.ey = CW'(ey);
    ln.color = PW'(color);
    lines_to_send.push_back(ln);
  endtask

  task automatic queue_random_lines(int count);
    int sx, sy, ex, ey, d, tmp;
    for (int i = 0; i < count; i++) begin
      sx = $urandom_range(0, CMAX);
      sy = $urandom_range(0, CMAX);
      ex = $urandom_range(0, CMAX);
      ey = $urandom_range(0, CMAX);
      case ($urandom_range(0, 19)) inside
        [0:6]: ;
        [7:12]: begin
          ex = nudge(sx);
          ey = nudge(sy);
        end
        [13:15]: begin
          // Close to 45 degrees, where the choice of major axis is decided.
          sx = $urandom_range(0, CMAX / 2);
          sy = $urandom_range(0, CMAX / 2);
          d = $urandom_range(0, CMAX / 2);
          ex = sx + d;
          ey = sy + d + int'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) begin
            sx = CMAX - sx;
            ex = CMAX - ex;
          end
          if ($urandom_range(0, 1)) begin
            tmp = sx; sx = ex; ex = tmp;
            tmp = sy; sy = ey; ey = tmp;
          end
        end
        [16:18]: begin
          if ($urandom_range(0, 1)) ey = sy;
          else ex = sx;
        end
        default: begin
          ex = sx;
          ey = sy;
        end
      endcase
      queue_line(sx, sy, ex, ey, $urandom_range(0, 3));
    end
  endtask

  task automatic wait_all_drawn();
    while (lines_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        trace_line(on_offer);
        lines_drawn++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (lines_to_send.size() != 0) begin
          on_offer = lines_to_send.pop_front();
          start_x_i <= on_offer.sx;
          start_y_i <= on_offer.sy;
          end_x_i <= on_offer.ex;
          end_y_i <= on_offer.ey;
          pen_color_i <= on_offer.color;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern changes every so often.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(10, 150);
      end else begin
        stall_left--;
      end
      if (draining) begin
        out_stall_i <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d color=%0d last=%0d",
                 $time, pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", want.x, pixel_x_o);
        check_field("pixel_y", want.y, pixel_y_o);
        check_field("pixel_color", want.color, pixel_color_o);
        check_field("last_pixel", want.last, last_pixel_o);
        pixels_seen++;
      end
    end
  end

  // Watchdog: gives up when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Single pixels, full-length axis lines in both directions and both diagonals.
    queue_line(0, 0, 0, 0, 0);
    queue_line(CMAX, CMAX, CMAX, CMAX, 3);
    queue_line(0, 0, CMAX, 0, 1);
    queue_line(CMAX, CMAX, 0, CMAX, 2);
    queue_line(0, 0, 0, CMAX, 3);
    queue_line(CMAX, CMAX, CMAX, 0, 0);
    queue_line(0, 0, CMAX, CMAX, 1);
    queue_line(CMAX, 0, 0, CMAX, 2);
    queue_line(0, CMAX, CMAX, 0, 3);
    // Shallow and steep lines with the minor coordinate rising and falling.
    queue_line(0, 10, CMAX, 20, 0);
    queue_line(CMAX, 10, 0, 20, 1);
    queue_line(10, 0, 20, CMAX, 2);
    queue_line(20, CMAX, 10, 0, 3);
    queue_line(5, 40, 50, 2, 0);
    queue_line(0, 0, CMAX, 1, 1);
    queue_line(0, 0, 1, CMAX, 2);
    // One step off 45 degrees either way, and very short lines.
    queue_line(3, 3, 13, 14, 0);
    queue_line(3, 3, 14, 13, 3);
    queue_line(30, 30, 31, 32, 1);
    queue_line(42, 21, 41, 21, 2);
    queue_line(21, 42, 21, 43, 3);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_all_drawn();
    queue_random_lines(90);
    // The next batch is queued only once every pixel so far has been transferred.
    wait_all_drawn();
    queue_random_lines(90);
    wait_all_drawn();
    draining <= 1'b1;
    repeat (20) @(posedge clk_i);
    $display("Drew %0d lines in every octant with all four pen colours; %0d pixels checked.",
             lines_drawn, pixels_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lras_pkg.sv
design/lras_ctrl.sv
design/lras_dp.sv
design/line_rasterizer.sv
test/tb_line_rasterizer.sv
